>>> hdl/sua_pkg.sv
// ----------------------------------------------------------------------------
// sua_pkg
// Shared types, constants, microcode and index helpers for the stack unit.
// ----------------------------------------------------------------------------
package sua_pkg;

  // Storage geometry
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SUM_W       = CNT_W + 1;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned UPC_W       = 5;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [UPC_W-1:0]  upc_t;

  // Command and status codes
  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_SWAP = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_ROTL = 3'd5,
    CMD_ROTR = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Channel payloads
  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] top_value;
    logic [DEPTH_W-1:0] depth;
  } out_t;

  // Control word fields
  typedef enum logic [2:0] {
    C_NEVER  = 3'd0,
    C_ALWAYS = 3'd1,
    C_FULL   = 3'd2,
    C_EMPTY  = 3'd3,
    C_LT2    = 3'd4
  } cond_e;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_TOP  = 2'd1,
    RD_SEC  = 2'd2,
    RD_BOT  = 2'd3
  } rd_sel_e;

  typedef enum logic [2:0] {
    WA_TOP   = 3'd0,
    WA_SEC   = 3'd1,
    WA_BELOW = 3'd2,
    WA_PUSH  = 3'd3,
    WA_UP    = 3'd4
  } wa_sel_e;

  typedef enum logic [1:0] {
    WD_PUSH  = 2'd0,
    WD_RDATA = 2'd1,
    WD_A     = 2'd2,
    WD_ALU   = 2'd3
  } wd_sel_e;

  typedef enum logic [1:0] {
    ALU_NONE = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_MUL  = 2'd2
  } alu_e;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_INC  = 2'd1,
    PTR_DEC  = 2'd2,
    PTR_PUSH = 2'd3
  } ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  typedef struct packed {
    cond_e   cond;
    upc_t    target;
    rd_sel_e rd_sel;
    logic    ld_a;
    alu_e    alu;
    logic    wr_en;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    ptr_op_e ptr_op;
    cnt_op_e cnt_op;
    logic    set_status;
    status_e new_status;
    logic    emit;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   start;
    uword_t uw;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic full;
    logic empty;
    logic lt2;
    logic out_free;
  } flags_t;

  // Microcode addresses
  localparam upc_t UA_P0     = 5'd0;
  localparam upc_t UA_P1     = 5'd1;
  localparam upc_t UA_Q0     = 5'd2;
  localparam upc_t UA_Q1     = 5'd3;
  localparam upc_t UA_S0     = 5'd4;
  localparam upc_t UA_S1     = 5'd5;
  localparam upc_t UA_S2     = 5'd6;
  localparam upc_t UA_S3     = 5'd7;
  localparam upc_t UA_U0     = 5'd8;
  localparam upc_t UA_U1     = 5'd9;
  localparam upc_t UA_U2     = 5'd10;
  localparam upc_t UA_M0     = 5'd11;
  localparam upc_t UA_M1     = 5'd12;
  localparam upc_t UA_M2     = 5'd13;
  localparam upc_t UA_AWB    = 5'd14;
  localparam upc_t UA_L0     = 5'd15;
  localparam upc_t UA_L1     = 5'd16;
  localparam upc_t UA_R0     = 5'd17;
  localparam upc_t UA_R1     = 5'd18;
  localparam upc_t UA_FIN    = 5'd19;
  localparam upc_t UA_OUT    = 5'd20;
  localparam upc_t UA_EFULL  = 5'd21;
  localparam upc_t UA_ESHORT = 5'd22;
  localparam upc_t UA_LAST   = UA_ESHORT;

  localparam uword_t UW_NOP = '{
    cond: C_NEVER, target: UA_P0, rd_sel: RD_NONE, ld_a: 1'b0, alu: ALU_NONE,
    wr_en: 1'b0, wa_sel: WA_TOP, wd_sel: WD_RDATA, ptr_op: PTR_HOLD,
    cnt_op: CNT_HOLD, set_status: 1'b0, new_status: ST_OK, emit: 1'b0
  };

  // Ring index helpers
  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(STACK_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? ptr_t'(STACK_DEPTH - 1) : p - ptr_t'(1);
  endfunction

  // p - n modulo the depth, for n no larger than the depth
  function automatic ptr_t ptr_sub(ptr_t p, cnt_t n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(STACK_DEPTH) - SUM_W'(n);
    if (sum >= SUM_W'(STACK_DEPTH)) begin
      sum = sum - SUM_W'(STACK_DEPTH);
    end
    return ptr_t'(sum);
  endfunction

  // Dispatch table: first step of each command
  function automatic upc_t cmd_entry(cmd_e c);
    upc_t a;
    case (c)
      CMD_PUSH: a = UA_P0;
      CMD_POP:  a = UA_Q0;
      CMD_SWAP: a = UA_S0;
      CMD_SUB:  a = UA_U0;
      CMD_MUL:  a = UA_M0;
      CMD_ROTL: a = UA_L0;
      CMD_ROTR: a = UA_R0;
      default:  a = UA_FIN;
    endcase
    return a;
  endfunction

  // Microprogram ROM
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = UW_NOP;
    case (a)
      // push: check for room, then write above the top
      UA_P0: begin
        w.cond = C_FULL; w.target = UA_EFULL;
      end
      UA_P1: begin
        w.wr_en = 1'b1; w.wa_sel = WA_PUSH; w.wd_sel = WD_PUSH;
        w.ptr_op = PTR_PUSH; w.cnt_op = CNT_INC;
        w.cond = C_ALWAYS; w.target = UA_FIN;
      end
      // pop: drop the top and fetch the new one
      UA_Q0: begin
        w.cond = C_EMPTY; w.target = UA_ESHORT;
      end
      UA_Q1: begin
        w.ptr_op = PTR_DEC; w.cnt_op = CNT_DEC; w.rd_sel = RD_SEC;
        w.cond = C_ALWAYS; w.target = UA_OUT;
      end
      // swap: fetch both, write each to the other's place
      UA_S0: begin
        w.cond = C_LT2; w.target = UA_ESHORT; w.rd_sel = RD_TOP;
      end
      UA_S1: begin
        w.ld_a = 1'b1; w.rd_sel = RD_SEC;
      end
      UA_S2: begin
        w.wr_en = 1'b1; w.wa_sel = WA_TOP; w.wd_sel = WD_RDATA;
      end
      UA_S3: begin
        w.wr_en = 1'b1; w.wa_sel = WA_SEC; w.wd_sel = WD_A; w.rd_sel = RD_TOP;
        w.cond = C_ALWAYS; w.target = UA_OUT;
      end
      // sub: second minus top
      UA_U0: begin
        w.cond = C_LT2; w.target = UA_ESHORT; w.rd_sel = RD_TOP;
      end
      UA_U1: begin
        w.ld_a = 1'b1; w.rd_sel = RD_SEC;
      end
      UA_U2: begin
        w.alu = ALU_SUB; w.cond = C_ALWAYS; w.target = UA_AWB;
      end
      // mul: second times top
      UA_M0: begin
        w.cond = C_LT2; w.target = UA_ESHORT; w.rd_sel = RD_TOP;
      end
      UA_M1: begin
        w.ld_a = 1'b1; w.rd_sel = RD_SEC;
      end
      UA_M2: begin
        w.alu = ALU_MUL;
      end
      // arithmetic write-back into the second entry, then pop
      UA_AWB: begin
        w.wr_en = 1'b1; w.wa_sel = WA_SEC; w.wd_sel = WD_ALU;
        w.ptr_op = PTR_DEC; w.cnt_op = CNT_DEC;
        w.cond = C_ALWAYS; w.target = UA_FIN;
      end
      // rotl: copy top below the bottom, move top down
      UA_L0: begin
        w.cond = C_LT2; w.target = UA_FIN; w.rd_sel = RD_TOP;
      end
      UA_L1: begin
        w.wr_en = 1'b1; w.wa_sel = WA_BELOW; w.wd_sel = WD_RDATA;
        w.ptr_op = PTR_DEC; w.rd_sel = RD_SEC;
        w.cond = C_ALWAYS; w.target = UA_OUT;
      end
      // rotr: copy bottom above the top, move top up
      UA_R0: begin
        w.cond = C_LT2; w.target = UA_FIN; w.rd_sel = RD_BOT;
      end
      UA_R1: begin
        w.wr_en = 1'b1; w.wa_sel = WA_UP; w.wd_sel = WD_RDATA;
        w.ptr_op = PTR_INC; w.cond = C_ALWAYS; w.target = UA_FIN;
      end
      // fetch the top for the result, then hand it over
      UA_FIN: begin
        w.rd_sel = RD_TOP;
      end
      UA_OUT: begin
        w.emit = 1'b1;
      end
      UA_EFULL: begin
        w.set_status = 1'b1; w.new_status = ST_FULL; w.rd_sel = RD_TOP;
        w.cond = C_ALWAYS; w.target = UA_OUT;
      end
      UA_ESHORT: begin
        w.set_status = 1'b1; w.new_status = ST_SHORT; w.rd_sel = RD_TOP;
        w.cond = C_ALWAYS; w.target = UA_OUT;
      end
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/sua_sequencer.sv
// ----------------------------------------------------------------------------
// sua_sequencer
// Step counter and microcode ROM; dispatches commands and resolves jumps.
// ----------------------------------------------------------------------------
module sua_sequencer
  import sua_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  cmd_e   in_cmd_i,
  output logic   in_ready_o,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  seq_state_e state_q, state_d;
  upc_t       upc_q, upc_d;
  uword_t     uw;
  logic       jump;

  // Fetch the current control word
  assign uw = ucode(upc_q);

  // Resolve the jump condition
  always_comb begin
    case (uw.cond)
      C_ALWAYS: jump = 1'b1;
      C_FULL:   jump = flags_i.full;
      C_EMPTY:  jump = flags_i.empty;
      C_LT2:    jump = flags_i.lt2;
      default:  jump = 1'b0;
    endcase
  end

  // Next state and step
  always_comb begin
    state_d = state_q;
    upc_d   = upc_q;
    case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          state_d = SEQ_RUN;
          upc_d   = cmd_entry(in_cmd_i);
        end
      end
      SEQ_RUN: begin
        if (uw.emit) begin
          // hold on the result step until the output slot frees up
          if (flags_i.out_free) begin
            state_d = SEQ_IDLE;
          end
        end else if (jump) begin
          upc_d = uw.target;
        end else begin
          upc_d = upc_q + upc_t'(1);
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    case (state_q)
      SEQ_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.start = in_valid_i;
        ctrl_o.uw    = UW_NOP;
      end
      SEQ_RUN: begin
        in_ready_o   = 1'b0;
        ctrl_o.start = 1'b0;
        ctrl_o.uw    = uw;
      end
      default: begin
        in_ready_o   = 1'b0;
        ctrl_o.start = 1'b0;
        ctrl_o.uw    = UW_NOP;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      upc_q   <= UA_P0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.start |=> (state_q == SEQ_RUN))
    else $error("sequencer did not start after a transaction");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) |-> (upc_q <= UA_LAST))
    else $error("step counter left the microprogram");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN && uw.emit && !flags_i.out_free)
      |=> (state_q == SEQ_RUN && $stable(upc_q)))
    else $error("result step left while output slot was busy");

endmodule

>>> hdl/sua_datapath.sv
// ----------------------------------------------------------------------------
// sua_datapath
// Ring-buffer stack memory, pointers, operand and ALU registers, result slot.
// ----------------------------------------------------------------------------
module sua_datapath
  import sua_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctrl_t  ctrl_i,
  input  in_t    in_data_i,
  output flags_t flags_o,
  input  logic   out_ready_i,
  output logic   out_valid_o,
  output out_t   out_data_o
);

  word_t   mem [STACK_DEPTH];
  ptr_t    ptr_q, ptr_d;
  cnt_t    cnt_q, cnt_d;
  word_t   val_q;
  word_t   a_q;
  word_t   alu_q, alu_d;
  word_t   rdata_q;
  status_e status_q;
  logic    out_valid_q;
  out_t    out_q;

  uword_t  uw;
  ptr_t    addr_sec, addr_bot, addr_below, addr_up, addr_push;
  ptr_t    rd_addr, wr_addr;
  word_t   wr_data;
  word_t   mul_lo;
  cnt_t    bot_dist;
  logic    emit_fire;

  assign uw = ctrl_i.uw;

  // Flags for the jump conditions
  assign flags_o.full     = (cnt_q == cnt_t'(STACK_DEPTH));
  assign flags_o.empty    = (cnt_q == '0);
  assign flags_o.lt2      = (cnt_q < cnt_t'(2));
  assign flags_o.out_free = !out_valid_q || out_ready_i;

  // Ring addresses around the top
  assign bot_dist   = flags_o.empty ? '0 : cnt_q - cnt_t'(1);
  assign addr_sec   = ptr_dec(ptr_q);
  assign addr_bot   = ptr_sub(ptr_q, bot_dist);
  assign addr_below = ptr_sub(ptr_q, cnt_q);
  assign addr_up    = ptr_inc(ptr_q);
  assign addr_push  = flags_o.empty ? ptr_q : addr_up;

  // Select read address
  always_comb begin
    case (uw.rd_sel)
      RD_SEC:  rd_addr = addr_sec;
      RD_BOT:  rd_addr = addr_bot;
      default: rd_addr = ptr_q;
    endcase
  end

  // Select write address and data
  always_comb begin
    case (uw.wa_sel)
      WA_SEC:   wr_addr = addr_sec;
      WA_BELOW: wr_addr = addr_below;
      WA_PUSH:  wr_addr = addr_push;
      WA_UP:    wr_addr = addr_up;
      default:  wr_addr = ptr_q;
    endcase
  end

  always_comb begin
    case (uw.wd_sel)
      WD_PUSH: wr_data = val_q;
      WD_A:    wr_data = a_q;
      WD_ALU:  wr_data = alu_q;
      default: wr_data = rdata_q;
    endcase
  end

  // Stack memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (uw.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (uw.rd_sel != RD_NONE) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // ALU: second operand arrives on the read port, first from the A register
  assign mul_lo = word_t'(rdata_q * a_q);

  always_comb begin
    case (uw.alu)
      ALU_SUB: alu_d = rdata_q - a_q;
      ALU_MUL: alu_d = mul_lo;
      default: alu_d = alu_q;
    endcase
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      val_q <= word_t'(in_data_i.push_value);
    end
    if (uw.ld_a) begin
      a_q <= rdata_q;
    end
    alu_q <= alu_d;
  end

  // Advance pointer and count
  always_comb begin
    case (uw.ptr_op)
      PTR_INC:  ptr_d = addr_up;
      PTR_DEC:  ptr_d = addr_sec;
      PTR_PUSH: ptr_d = addr_push;
      default:  ptr_d = ptr_q;
    endcase
    case (uw.cnt_op)
      CNT_INC: cnt_d = cnt_q + cnt_t'(1);
      CNT_DEC: cnt_d = cnt_q - cnt_t'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      cnt_q    <= '0;
      status_q <= ST_OK;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (ctrl_i.start) begin
        status_q <= ST_OK;
      end else if (uw.set_status) begin
        status_q <= uw.new_status;
      end
    end
  end

  // Result slot: load on the result step, drop on the output transaction
  assign emit_fire = uw.emit && flags_o.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.status    <= status_q;
      out_q.top_value <= flags_o.empty ? '0 : $signed(rdata_q);
      out_q.depth     <= DEPTH_W'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_no_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.cnt_op == CNT_DEC) |-> !flags_o.empty)
    else $error("drop on an empty stack");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.cnt_op == CNT_INC) |-> !flags_o.full)
    else $error("push on a full stack");

endmodule

>>> hdl/stack_unit_arith_rotate_top.sv
// ----------------------------------------------------------------------------
// stack_unit_arith_rotate_top
// Bounded stack of signed 32-bit words running one command per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries a command
//   (push, pop, swap, sub, mul, rotl, rotr) and a push value. Every command
//   returns one result on the output channel (out_valid_o / out_ready_i /
//   out_data_o): status, the top entry after the command (zero when empty)
//   and the entry count.
//   Sequencing: a microcoded sequencer runs each command as a short program
//   over one stack memory with a write port and a registered read port. The
//   result is loaded into the output register on the program's result step,
//   and the input is ready again the cycle after the result is loaded.
//   Reset empties the stack (pointer and count to zero); memory contents are
//   not cleared and need no clearing pass.
//   Stall: the result sits in an output register; the block accepts and runs
//   the next command while it waits and holds on that command's result step
//   until the register is taken.
// ----------------------------------------------------------------------------
module stack_unit_arith_rotate_top
  import sua_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  ctrl_t  ctrl;
  flags_t flags;

  // Step counter and control store
  sua_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  // Stack memory and arithmetic
  sua_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_data_i   (in_data_i),
    .flags_o     (flags),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
